@@ rtl/atipd_pkg.sv @@
// ----------------------------------------------------------------------------
// atipd_pkg
// shared types and character codes for the +IPD frame parser
// ----------------------------------------------------------------------------
package atipd_pkg;

  // length field
  localparam int          LenW         = 14;
  localparam logic [13:0] LenMax       = 14'd16383;
  localparam int          MaxLenDigits = 4;
  localparam int          DigitCntW    = 3;

  // packed width of the result tdata
  localparam int TdataOutW = 24;

  // beat kinds on the slave side
  localparam logic CmdByte  = 1'b0;
  localparam logic CmdClear = 1'b1;

  // characters
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharI     = 8'h49;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharO     = 8'h4F;
  localparam logic [7:0] CharK     = 8'h4B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [6:0] {
    ST_PLUS  = 7'b0000001,
    ST_I     = 7'b0000010,
    ST_P     = 7'b0000100,
    ST_D     = 7'b0001000,
    ST_COMMA = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_DATA  = 7'b1000000
  } parse_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]      payload_byte;
    logic            payload_valid;
    logic            payload_last;
    logic [LenW-1:0] payload_length;
    logic            ready_flag;
  } result_t;

endpackage

@@ rtl/atipd_in_stage.sv @@
// ----------------------------------------------------------------------------
// atipd_in_stage
// input register: holds one slave-side beat until the step logic takes it
// ----------------------------------------------------------------------------
module atipd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  atipd_pkg::item_t  in_item,
  input  logic              take,
  output logic              valid,
  output atipd_pkg::item_t  item
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/atipd_step.sv @@
// ----------------------------------------------------------------------------
// atipd_step
// parser state and its single-pass next-state logic for one beat
// ----------------------------------------------------------------------------
module atipd_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  atipd_pkg::item_t    item,
  output atipd_pkg::result_t  res
);

  atipd_pkg::parse_state_t parse_state, parse_state_next;
  logic                           ok_match, ok_match_next;
  logic                           ready_bit, ready_bit_next;
  logic [atipd_pkg::LenW-1:0]     frame_length, frame_length_next;
  logic [atipd_pkg::LenW-1:0]     byte_count, byte_count_next;
  logic [atipd_pkg::DigitCntW-1:0] digit_count, digit_count_next;
  logic                           digits_ended, digits_ended_next;

  logic [7:0]                     c;
  logic [3:0]                     digit;
  logic                           is_digit;
  logic [17:0]                    len_mac;
  logic [atipd_pkg::LenW-1:0]     len_sat;
  logic [atipd_pkg::LenW-1:0]     byte_inc;
  logic                           ready_mid;

  assign c        = item.rx_byte;
  assign digit    = c[3:0];
  assign is_digit = (c >= atipd_pkg::CharZero) && (c <= atipd_pkg::CharNine);
  // frame_length * 10 + digit
  assign len_mac  = {1'b0, frame_length, 3'b000} + {3'b000, frame_length, 1'b0}
                  + {14'b0, digit};
  assign len_sat  = (len_mac > 18'(atipd_pkg::LenMax)) ? atipd_pkg::LenMax
                                                       : len_mac[13:0];
  assign byte_inc = byte_count + 14'd1;

  always_comb begin
    parse_state_next   = parse_state;
    ok_match_next      = ok_match;
    ready_bit_next     = ready_bit;
    frame_length_next  = frame_length;
    byte_count_next    = byte_count;
    digit_count_next   = digit_count;
    digits_ended_next  = digits_ended;
    ready_mid          = ready_bit;
    res.payload_byte   = 8'd0;
    res.payload_valid  = 1'b0;
    res.payload_last   = 1'b0;

    if (item.cmd == atipd_pkg::CmdClear) begin
      ready_bit_next = 1'b0;
    end else begin
      case (parse_state)
        atipd_pkg::ST_I: begin
          parse_state_next = (c == atipd_pkg::CharI) ? atipd_pkg::ST_P
                                                     : atipd_pkg::ST_PLUS;
        end
        atipd_pkg::ST_P: begin
          parse_state_next = (c == atipd_pkg::CharP) ? atipd_pkg::ST_D
                                                     : atipd_pkg::ST_PLUS;
        end
        atipd_pkg::ST_D: begin
          parse_state_next = (c == atipd_pkg::CharD) ? atipd_pkg::ST_COMMA
                                                     : atipd_pkg::ST_PLUS;
        end
        atipd_pkg::ST_COMMA: begin
          if (c == atipd_pkg::CharComma) begin
            parse_state_next  = atipd_pkg::ST_LEN;
            frame_length_next = '0;
            digit_count_next  = '0;
            digits_ended_next = 1'b0;
          end else begin
            parse_state_next = atipd_pkg::ST_PLUS;
          end
        end
        atipd_pkg::ST_LEN: begin
          if (c == atipd_pkg::CharColon) begin
            byte_count_next  = '0;
            // empty frame goes straight back to hunting
            parse_state_next = (frame_length == '0) ? atipd_pkg::ST_PLUS
                                                    : atipd_pkg::ST_DATA;
          end else if (is_digit) begin
            if (!digits_ended &&
                (digit_count < atipd_pkg::DigitCntW'(atipd_pkg::MaxLenDigits))) begin
              frame_length_next = len_sat;
              digit_count_next  = digit_count + 3'd1;
            end
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        atipd_pkg::ST_DATA: begin
          res.payload_byte  = c;
          res.payload_valid = 1'b1;
          byte_count_next   = byte_inc;
          if (byte_inc >= frame_length) begin
            res.payload_last = 1'b1;
            byte_count_next  = '0;
            parse_state_next = atipd_pkg::ST_PLUS;
          end
        end
        default: begin
          parse_state_next = (c == atipd_pkg::CharPlus) ? atipd_pkg::ST_I
                                                        : atipd_pkg::ST_PLUS;
        end
      endcase

      // prompt / OK detection runs on every received byte
      ready_mid      = ready_bit || (c == atipd_pkg::CharGt);
      ready_bit_next = ready_mid;
      if (!ready_mid) begin
        if (!ok_match) begin
          ok_match_next = (c == atipd_pkg::CharO);
        end else begin
          ok_match_next = 1'b0;
          if (c == atipd_pkg::CharK) begin
            ready_bit_next = 1'b1;
          end
        end
      end
    end

    res.payload_length = frame_length_next;
    res.ready_flag     = ready_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state  <= atipd_pkg::ST_PLUS;
      ok_match     <= 1'b0;
      ready_bit    <= 1'b0;
      frame_length <= '0;
      byte_count   <= '0;
      digit_count  <= '0;
      digits_ended <= 1'b0;
    end else if (en) begin
      parse_state  <= parse_state_next;
      ok_match     <= ok_match_next;
      ready_bit    <= ready_bit_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      digit_count  <= digit_count_next;
      digits_ended <= digits_ended_next;
    end
  end

endmodule

@@ rtl/at_response_ipd_parser_core.sv @@
// ----------------------------------------------------------------------------
// at_response_ipd_parser_core
// +IPD frame parser and OK / prompt detector for a modem receive byte stream
// ----------------------------------------------------------------------------
// path: input register then result register; a beat accepted into the input
//   register steps into the result register, which holds it until m_axis_tready
// throughput: one beat per cycle unless m_axis_tready stalls the result register;
//   one result beat for every input beat, made by a single pass through the step logic
// reset: synchronous active-high rst empties both registers, puts the parser
//   in the hunt-for-plus state and clears the ready flag and length state
// ----------------------------------------------------------------------------
module at_response_ipd_parser_core (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] cmd (0 = byte, 1 = clear ready flag)
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [21:8] payload_length,
                                      // [22] ready_flag, [23] zero
  output logic        m_axis_tuser,   // [0] payload_valid
  output logic        m_axis_tlast    // payload_last
);

  atipd_pkg::item_t   in_item;
  atipd_pkg::item_t   st_item;
  logic               st_valid;
  logic               adv;
  atipd_pkg::result_t step_res;
  atipd_pkg::result_t out_res;
  logic               out_valid;

  assign in_item.cmd     = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  // a beat moves into the result register whenever that register is free
  // or is being drained this cycle; parser state advances with it
  assign adv = st_valid && (!out_valid || m_axis_tready);

  atipd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .take     (adv),
    .valid    (st_valid),
    .item     (st_item)
  );

  atipd_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .item (st_item),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.ready_flag, out_res.payload_length,
                          out_res.payload_byte};
  assign m_axis_tuser  = out_res.payload_valid;
  assign m_axis_tlast  = out_res.payload_last;

  // last beat of a frame is always a payload beat
  a_last_is_payload: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("tlast without payload");

  // non-payload beats carry a zero byte
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero byte on non-payload beat");

  // a clear command shows a dropped ready flag on its own result beat
  a_clear_drops_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && (st_item.cmd == atipd_pkg::CmdClear)) |=> !m_axis_tdata[22])
    else $error("ready flag survived clear");

  // every step produces a result beat in the next cycle
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("result beat lost");

endmodule
